// File: design/obd_pkg.sv
// Shared constants and types for the order book depth merge block.
package obd_pkg;
  localparam int LEVELS = 64;
  localparam int PW = 48;
  localparam int SW = 48;
  localparam int TW = 63;
  localparam int CW = $clog2(LEVELS + 1);
  localparam logic [SW-1:0] SMAX = {SW{1'b1}};

  localparam logic OP_SNAPSHOT = 1'b0;
  localparam logic SIDE_ASK = 1'b0;

  // chain command, broadcast to every cell of one side
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_SETTOP = 2'd3;

  typedef struct packed {
    logic [1:0]    cmd;
    logic          is_bid;
    logic [PW-1:0] price;
    logic [SW-1:0] size;
  } obd_cmd_t;

  typedef struct packed {
    logic [PW-1:0] price;
    logic [SW-1:0] size;
  } obd_level_t;

  typedef struct packed {
    logic         operation;
    logic         first_of_update;
    logic         last_of_update;
    logic         side;
    logic [PW-1:0] price;
    logic [SW-1:0] size;
    logic [TW-1:0] timestamp;
  } obd_in_t;

  typedef struct packed {
    logic [PW-1:0] best_ask_price;
    logic [SW-1:0] best_ask_size;
    logic [PW-1:0] best_bid_price;
    logic [SW-1:0] best_bid_size;
    logic [CW-1:0] ask_count;
    logic [CW-1:0] bid_count;
    logic          level_dropped;
    logic [TW-1:0] book_time;
  } obd_out_t;
endpackage

// File: design/obd_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface obd_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/order_book_depth_merge_core.sv
// Top level of the order book depth merge block.
//  channel | dir | payload
//  in      | in  | obd_in_t: one price level of an update
//  out     | out | obd_out_t: book top after the level
// An item passes through accept, insert and result; on the last level of an
// incremental update, matching steps run after insert until the book is seen
// uncrossed. The chain shifts in parallel on insert.
// Reset (rst, synchronous) empties both sides and zeroes book time.
// A result waits in the output register; the next item is taken meanwhile, and
// its result holds until the register frees.
module order_book_depth_merge_core import obd_pkg::*; (
  input logic clk,
  input logic rst,
  obd_stream_if.sink   in,
  obd_stream_if.source out
);
  localparam logic [1:0] S_IDLE = 2'd0, S_INS = 2'd1, S_MATCH = 2'd2, S_DONE = 2'd3;
  logic [1:0] state;
  obd_in_t item;
  obd_cmd_t ask_cmd, bid_cmd;
  obd_level_t ask_top, bid_top;
  logic [CW-1:0] ask_cnt, bid_cnt;
  logic ask_drop, bid_drop, drop_q, clear, crossed;
  logic [TW-1:0] book_time;
  logic setask, setbid;
  logic [SW-1:0] new_size;

  assign in.ready = state == S_IDLE;
  assign clear = in.valid && in.ready && in.data.operation == OP_SNAPSHOT &&
                 in.data.first_of_update;
  assign crossed = ask_cnt != '0 && bid_cnt != '0 && ask_top.price <= bid_top.price;

  always_comb begin
    ask_cmd = '{cmd: CMD_HOLD, is_bid: 1'b0, price: item.price, size: item.size};
    bid_cmd = '{cmd: CMD_HOLD, is_bid: 1'b1, price: item.price, size: item.size};
    setask = 1'b0;
    setbid = 1'b0;
    new_size = '0;
    if (state == S_INS) begin
      if (item.side == SIDE_ASK) ask_cmd.cmd = CMD_INSERT;
      else bid_cmd.cmd = CMD_INSERT;
    end else if (state == S_MATCH && crossed) begin
      if (ask_top.size > bid_top.size) begin
        bid_cmd.cmd = CMD_POP;
        setask = 1'b1;
        new_size = ask_top.size - bid_top.size;
      end else begin
        ask_cmd.cmd = CMD_POP;
        setbid = 1'b1;
        new_size = bid_top.size - ask_top.size;
      end
    end
    // write the reduced size into the top cell
    if (setask) begin
      ask_cmd.cmd = CMD_SETTOP;
      ask_cmd.size = new_size;
    end
    if (setbid) begin
      bid_cmd.cmd = CMD_SETTOP;
      bid_cmd.size = new_size;
    end
  end

  obd_side u_ask (.clk(clk), .rst(rst), .cmd(ask_cmd), .clear(clear),
    .top(ask_top), .count(ask_cnt), .dropped(ask_drop));
  obd_side u_bid (.clk(clk), .rst(rst), .cmd(bid_cmd), .clear(clear),
    .top(bid_top), .count(bid_cnt), .dropped(bid_drop));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      book_time <= '0;
    end else begin
      if (out.valid && out.ready && state != S_DONE) out.valid <= 1'b0;
      case (state)
        S_IDLE: if (in.valid) begin
          item <= in.data;
          book_time <= in.data.timestamp;
          state <= S_INS;
        end
        S_INS: begin
          drop_q <= ask_drop | bid_drop;
          state <= (item.operation != OP_SNAPSHOT && item.last_of_update) ?
                   S_MATCH : S_DONE;
        end
        S_MATCH: if (!crossed) state <= S_DONE;
        S_DONE: if (!out.valid || out.ready) begin
          out.valid <= 1'b1;
          out.data <= '{best_ask_price: ask_cnt != '0 ? ask_top.price : '0,
                        best_ask_size:  ask_cnt != '0 ? ask_top.size : '0,
                        best_bid_price: bid_cnt != '0 ? bid_top.price : '0,
                        best_bid_size:  bid_cnt != '0 ? bid_top.size : '0,
                        ask_count: ask_cnt, bid_count: bid_cnt,
                        level_dropped: drop_q, book_time: book_time};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    ask_cnt <= CW'(LEVELS) && bid_cnt <= CW'(LEVELS)) else $error("count overflow");
  a_uncrossed: assert property (@(posedge clk) disable iff (rst)
    state == S_MATCH && !crossed |=> state == S_DONE) else $error("match exit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid) else $error("result lost");
endmodule

// File: design/obd_cell.sv
// One price level cell of a sorted side chain.
module obd_cell import obd_pkg::*; (
  input  logic       clk,
  input  obd_cmd_t   cmd,
  input  logic       occ,      // this cell holds a level
  input  logic       prev_occ,
  input  logic       prev_after, // upstream cell decided the new level goes after it
  input  logic       merge,    // an equal price is held somewhere on this side
  input  obd_level_t prev_lvl,
  input  obd_level_t next_lvl,
  output obd_level_t lvl,
  output logic       hit,      // equal price held here
  output logic       after     // new level ranks behind this cell (or hit)
);
  logic ahead;
  assign hit = occ && lvl.price == cmd.price;
  assign ahead = cmd.is_bid ? (cmd.price > lvl.price) : (cmd.price < lvl.price);
  assign after = occ && !ahead;

  always_ff @(posedge clk) begin
    case (cmd.cmd)
      CMD_INSERT: begin
        if (hit) begin
          lvl.size <= (({1'b0, lvl.size} + {1'b0, cmd.size}) > {1'b0, SMAX}) ?
                      SMAX : lvl.size + cmd.size;
        end else if (prev_after && !after && !merge) begin
          lvl <= '{price: cmd.price, size: cmd.size};
        end else if (!prev_after && prev_occ) begin
          lvl <= prev_lvl;
        end
      end
      CMD_POP: lvl <= next_lvl;
      // only the first held cell has no held neighbor upstream
      CMD_SETTOP: if (occ && !prev_occ) lvl.size <= cmd.size;
      default: ;
    endcase
  end
endmodule

// File: design/obd_side.sv
// One side of the book: a chain of level cells and its count.
module obd_side import obd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  obd_cmd_t   cmd,
  input  logic       clear,
  output obd_level_t top,
  output logic [CW-1:0] count,
  output logic       dropped
);
  obd_level_t lvl [LEVELS];
  logic [LEVELS-1:0] hit, after, occ;
  logic any_hit;
  logic [CW-1:0] count_next;
  obd_cmd_t cc;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) occ[i] = CW'(i) < count;
  end
  assign any_hit = |hit;

  // settop writes cell 0 size only
  assign cc = cmd;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    obd_cell u_cell (
      .clk(clk), .cmd(cc), .occ(occ[i]),
      .prev_occ(i == 0 ? 1'b0 : occ[(i == 0) ? 0 : i-1]),
      .prev_after(i == 0 ? 1'b1 : (after[(i == 0) ? 0 : i-1] | any_hit)),
      .merge(any_hit),
      .prev_lvl(lvl[(i == 0) ? 0 : i-1]),
      .next_lvl(lvl[(i == LEVELS-1) ? i : i+1]),
      .lvl(lvl[i]), .hit(hit[i]), .after(after[i]));
  end

  always_comb begin
    dropped = 1'b0;
    count_next = count;
    case (cmd.cmd)
      CMD_INSERT: begin
        if (!any_hit) begin
          if (count == CW'(LEVELS)) dropped = 1'b1;
          else count_next = count + 1'b1;
        end
      end
      CMD_POP: if (count != '0) count_next = count - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) count <= '0;
    else count <= count_next;
  end

  always_comb begin
    top = lvl[0];
  end
endmodule

// File: verif/order_book_depth_merge_tb.sv
// Testbench for the order book depth merge block: directed and random levels.
`timescale 1ns / 1ps
module testbench;
  import obd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  obd_stream_if #(.T(obd_in_t))  in_ch (clk);
  obd_stream_if #(.T(obd_out_t)) out_ch (clk);

  order_book_depth_merge_core dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // book image used for prediction
  logic [PW-1:0] ask_px [0:LEVELS-1];
  logic [SW-1:0] ask_sz [0:LEVELS-1];
  logic [PW-1:0] bid_px [0:LEVELS-1];
  logic [SW-1:0] bid_sz [0:LEVELS-1];
  int            ask_n;
  int            bid_n;
  obd_out_t      book_top_q [$];
  int            errors = 0;
  bit            quiet = 1'b0;
  bit            sink_stall_en = 1'b1;
  int            idle_cycles = 0;

  // insert one level on a side; returns 1 if a level was dropped
  function automatic bit book_insert(bit is_bid, logic [PW-1:0] p, logic [SW-1:0] s);
    int            n;
    int            pos;
    logic [SW:0]   sum;
    logic [PW-1:0] px [0:LEVELS-1];
    logic [SW-1:0] sz [0:LEVELS-1];
    bit            dropped;
    dropped = 1'b0;
    if (is_bid) begin
      px = bid_px; sz = bid_sz; n = bid_n;
    end else begin
      px = ask_px; sz = ask_sz; n = ask_n;
    end
    for (pos = 0; pos < n; pos++) begin
      if (px[pos] == p) begin
        sum = {1'b0, sz[pos]} + {1'b0, s};
        sz[pos] = sum[SW] ? SMAX : sum[SW-1:0];
        if (is_bid) bid_sz = sz; else ask_sz = sz;
        return 1'b0;
      end
      if (is_bid ? (p > px[pos]) : (p < px[pos])) break;
    end
    if (n == LEVELS) begin
      if (pos >= LEVELS) return 1'b1;
      n = LEVELS - 1;
      dropped = 1'b1;
    end
    for (int k = n; k > pos; k--) begin
      px[k] = px[k-1];
      sz[k] = sz[k-1];
    end
    px[pos] = p;
    sz[pos] = s;
    n++;
    if (is_bid) begin
      bid_px = px; bid_sz = sz; bid_n = n;
    end else begin
      ask_px = px; ask_sz = sz; ask_n = n;
    end
    return dropped;
  endfunction

  function automatic void match_crossed_levels();
    while (ask_n > 0 && bid_n > 0 && ask_px[0] <= bid_px[0]) begin
      if (ask_sz[0] > bid_sz[0]) begin
        ask_sz[0] = ask_sz[0] - bid_sz[0];
        for (int k = 1; k < bid_n; k++) begin
          bid_px[k-1] = bid_px[k]; bid_sz[k-1] = bid_sz[k];
        end
        bid_n--;
      end else begin
        bid_sz[0] = bid_sz[0] - ask_sz[0];
        for (int k = 1; k < ask_n; k++) begin
          ask_px[k-1] = ask_px[k]; ask_sz[k-1] = ask_sz[k];
        end
        ask_n--;
      end
    end
  endfunction

  function automatic obd_out_t predict_book_top(obd_in_t it);
    obd_out_t r;
    bit       dropped;
    if (it.operation == OP_SNAPSHOT && it.first_of_update) begin
      ask_n = 0;
      bid_n = 0;
    end
    dropped = book_insert(it.side != SIDE_ASK, it.price, it.size);
    if (it.operation != OP_SNAPSHOT && it.last_of_update) match_crossed_levels();
    r.best_ask_price = (ask_n != 0) ? ask_px[0] : '0;
    r.best_ask_size  = (ask_n != 0) ? ask_sz[0] : '0;
    r.best_bid_price = (bid_n != 0) ? bid_px[0] : '0;
    r.best_bid_size  = (bid_n != 0) ? bid_sz[0] : '0;
    r.ask_count      = CW'(ask_n);
    r.bid_count      = CW'(bid_n);
    r.level_dropped  = dropped;
    r.book_time      = it.timestamp;
    return r;
  endfunction

  task automatic send_level(obd_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book_top_q = {book_top_q, predict_book_top(it)};
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
  endtask

  function automatic obd_in_t make_level(bit op, bit first, bit last, bit side,
                                         logic [PW-1:0] p, logic [SW-1:0] s);
    obd_in_t it;
    it.operation = op;
    it.first_of_update = first;
    it.last_of_update = last;
    it.side = side;
    it.price = p;
    it.size = s;
    it.timestamp = TW'({$urandom, $urandom});
    return it;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // sink side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (!sink_stall_en) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    obd_out_t want;
    obd_out_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (book_top_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = book_top_q.pop_front();
        if (got.best_ask_price !== want.best_ask_price)
          $display("%0t: best_ask_price exp %h got %h", $time, want.best_ask_price,
                   got.best_ask_price);
        if (got.best_ask_size !== want.best_ask_size)
          $display("%0t: best_ask_size exp %h got %h", $time, want.best_ask_size,
                   got.best_ask_size);
        if (got.best_bid_price !== want.best_bid_price)
          $display("%0t: best_bid_price exp %h got %h", $time, want.best_bid_price,
                   got.best_bid_price);
        if (got.best_bid_size !== want.best_bid_size)
          $display("%0t: best_bid_size exp %h got %h", $time, want.best_bid_size,
                   got.best_bid_size);
        if (got.ask_count !== want.ask_count)
          $display("%0t: ask_count exp %0d got %0d", $time, want.ask_count, got.ask_count);
        if (got.bid_count !== want.bid_count)
          $display("%0t: bid_count exp %0d got %0d", $time, want.bid_count, got.bid_count);
        if (got.level_dropped !== want.level_dropped)
          $display("%0t: level_dropped exp %b got %b", $time, want.level_dropped,
                   got.level_dropped);
        if (got.book_time !== want.book_time)
          $display("%0t: book_time exp %h got %h", $time, want.book_time, got.book_time);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [PW-1:0] maxp;
    maxp = {PW{1'b1}};
    // snapshot opens, then continues without clearing
    send_level(make_level(1'b0, 1'b1, 1'b0, 1'b0, 48'd100, 48'd5));
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b1, 48'd90, 48'd7));
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, 48'd100, SMAX));  // saturating merge
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, maxp, 48'd0));    // zero size, top price
    send_level(make_level(1'b0, 1'b0, 1'b1, 1'b1, 48'd0, SMAX));    // snapshot last: no match
    // incremental, first flag ignored, crossing match
    send_level(make_level(1'b1, 1'b1, 1'b0, 1'b1, 48'd95, 48'd3));
    send_level(make_level(1'b1, 1'b0, 1'b1, 1'b1, 48'd100, 48'd4));
    send_level(make_level(1'b1, 1'b0, 1'b1, 1'b0, 48'd80, 48'd2));
    send_level(make_level(1'b1, 1'b1, 1'b1, 1'b1, maxp, 48'd1));
    // fill the ask side, then push worse and better prices
    send_level(make_level(1'b0, 1'b1, 1'b0, 1'b0, 48'd1000, 48'd1));
    for (int i = 1; i < LEVELS; i++)
      send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, 48'd1000 + 48'(i), 48'd1));
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, 48'd5000, 48'd1)); // worse: itself dropped
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, 48'd10, 48'd1));   // better: worst pushed out
    send_level(make_level(1'b0, 1'b0, 1'b0, 1'b0, 48'd1000, 48'd1)); // merge while full
  endtask

  task automatic test_random(int total, bit no_idle);
    int            sent;
    int            len;
    logic [PW-1:0] mid;
    sent = 0;
    quiet = no_idle;
    sink_stall_en = !no_idle;
    while (sent < total) begin
      mid = ($urandom_range(0, 9) == 0) ? rand48() : 48'(1000 + $urandom_range(0, 200));
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 4) == 0) begin
        // snapshot, sometimes of 60 to 80 levels over both sides
        if ($urandom_range(0, 5) == 0) len = $urandom_range(60, 80);
        for (int i = 0; i < len; i++) begin
          bit sd;
          sd = 1'($urandom_range(0, 1));
          send_level(make_level(1'b0, i == 0, i == len - 1, sd,
            sd ? mid - 48'($urandom_range(0, 70)) : mid + 48'($urandom_range(0, 70)),
            ($urandom_range(0, 15) == 0) ? rand48() : 48'($urandom_range(0, 50))));
        end
      end else if ($urandom_range(0, 9) == 0) begin
        // noise
        send_level(make_level(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand48(), rand48()));
        len = 1;
      end else begin
        for (int i = 0; i < len; i++) begin
          send_level(make_level(1'b1, i == 0, i == len - 1, 1'($urandom_range(0, 1)),
            mid + 48'($urandom_range(0, 40)) - 48'd20,
            ($urandom_range(0, 20) == 0) ? SMAX : 48'($urandom_range(0, 60))));
        end
      end
      sent += len;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    ask_n = 0;
    bid_n = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1000, 1'b0);
    test_random(300, 1'b1);
    go_idle();
    while (book_top_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: files.f
design/obd_pkg.sv
design/obd_stream_if.sv
design/obd_cell.sv
design/obd_side.sv
design/order_book_depth_merge_core.sv
verif/order_book_depth_merge_tb.sv
